// File: sv/wsfm_pkg.sv
// Shared types and constants for the masked WebSocket client framer.
// No dependencies; used by every module of the block.
package wsfm_pkg;

    localparam int unsigned S_TDATA_W = 112;
    localparam int unsigned M_TDATA_W = 8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [7:0] HDR_FIN      = 8'h80;
    localparam logic [7:0] HDR_MASK_BIT = 8'h80;
    localparam logic [3:0] NIBBLE_MASK  = 4'hf;
    localparam logic [6:0] LEN_CODE_16  = 7'd126;
    localparam logic [6:0] LEN_CODE_64  = 7'd127;
    localparam logic [6:0] LEN_CODE_MAX = 7'h7f;
    localparam logic [62:0] LEN_SHORT_MAX = 63'd125;

    localparam logic [3:0] EXT_BYTES_SHORT = 4'd0;
    localparam logic [3:0] EXT_BYTES_MID   = 4'd2;
    localparam logic [3:0] EXT_BYTES_LONG  = 4'd8;

    typedef enum logic [1:0] {
        JOB_ERROR  = 2'd0,
        JOB_HEADER = 2'd1,
        JOB_DATA   = 2'd2
    } job_kind_t;

    typedef enum logic [1:0] {
        LEN_SHORT = 2'd0,
        LEN_MID   = 2'd1,
        LEN_LONG  = 2'd2
    } len_class_t;

    typedef struct packed {
        job_kind_t   kind;
        len_class_t  lclass;
        logic [3:0]  opcode;
        logic [62:0] length;
        logic [31:0] key;
        logic [7:0]  data;
        logic        last;
    } job_t;

endpackage

// File: sv/wsfm_front.sv
// Front end: accepts input words, tracks frame state, classifies each word
// into a job for the back end. Depends on wsfm_pkg.
module wsfm_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wsfm_pkg::S_TDATA_W-1:0]    s_tdata,  // opcode, length, key, data byte
    input  logic [0:0]                        s_tuser,  // command
    input  logic                              q_full,
    output logic                              q_push,
    output wsfm_pkg::job_t                    q_job
);

    logic [62:0] rem_reg, rem_next;
    logic [31:0] held_key_reg, held_key_next;
    logic [1:0]  key_index_reg, key_index_next;
    logic        frame_open_reg, frame_open_next;

    logic        cmd;
    logic [3:0]  opc;
    logic [62:0] len;
    logic [31:0] key;
    logic [7:0]  data;
    logic [7:0]  cur_key_byte;
    logic [62:0] rem_dec;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        cmd  = s_tuser[0];
        opc  = s_tdata[3:0] & wsfm_pkg::NIBBLE_MASK;
        len  = s_tdata[66:4];
        key  = s_tdata[98:67];
        data = s_tdata[106:99];
        cur_key_byte = held_key_reg[{~key_index_reg, 3'b000} +: 8];
        rem_dec = rem_reg - 63'd1;

        rem_next        = rem_reg;
        held_key_next   = held_key_reg;
        key_index_next  = key_index_reg;
        frame_open_next = frame_open_reg;

        q_job.kind   = wsfm_pkg::JOB_ERROR;
        q_job.lclass = wsfm_pkg::LEN_SHORT;
        q_job.opcode = opc;
        q_job.length = len;
        q_job.key    = key;
        q_job.data   = data ^ cur_key_byte;
        q_job.last   = (rem_dec == 63'd0);

        if (len[62:16] != 47'd0) begin
            q_job.lclass = wsfm_pkg::LEN_LONG;
        end else if (len > wsfm_pkg::LEN_SHORT_MAX) begin
            q_job.lclass = wsfm_pkg::LEN_MID;
        end

        if (cmd == wsfm_pkg::CMD_START) begin
            if (!frame_open_reg) begin
                q_job.kind = wsfm_pkg::JOB_HEADER;
                if (q_push) begin
                    held_key_next   = key;
                    key_index_next  = 2'd0;
                    rem_next        = len;
                    frame_open_next = (len != 63'd0);
                end
            end
        end else begin
            if (frame_open_reg) begin
                q_job.kind = wsfm_pkg::JOB_DATA;
                if (q_push) begin
                    rem_next        = rem_dec;
                    key_index_next  = key_index_reg + 2'd1;
                    frame_open_next = (rem_dec != 63'd0);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg        <= '0;
            held_key_reg   <= '0;
            key_index_reg  <= '0;
            frame_open_reg <= 1'b0;
        end else begin
            rem_reg        <= rem_next;
            held_key_reg   <= held_key_next;
            key_index_reg  <= key_index_next;
            frame_open_reg <= frame_open_next;
        end
    end

    a_open_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_open_reg == (rem_reg != 63'd0))
        else $error("frame open flag disagrees with remaining count");

endmodule

// File: sv/wsfm_queue.sv
// Short job queue between front and back ends.
// Depends on wsfm_pkg for the job type.
module wsfm_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  wsfm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output wsfm_pkg::job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    wsfm_pkg::job_t store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_job   = store_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !do_push)
        else $error("queue written while full");

endmodule

// File: sv/wsfm_back.sv
// Back end: expands header jobs into header and key bytes, passes data and
// error jobs, and holds the registered output word. Depends on wsfm_pkg.
module wsfm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  wsfm_pkg::job_t                    head_job,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wsfm_pkg::M_TDATA_W-1:0]    m_tdata,  // wire byte
    output logic                              m_tlast,
    output logic [0:0]                        m_tuser   // error flag
);

    logic [3:0] pos_reg, pos_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       m_tuser_reg, m_tuser_next;

    logic        out_adv;
    logic        step;
    logic [3:0]  n_ext;
    logic [3:0]  last_pos;
    logic [3:0]  ext_idx;
    logic [3:0]  ext_sel;
    logic [3:0]  key_idx;
    logic [6:0]  len_code;
    logic [63:0] len64;
    logic [7:0]  hdr_byte;

    assign out_adv = !m_tvalid_reg || m_tready;
    assign step    = head_valid && out_adv;

    always_comb begin
        case (head_job.lclass)
            wsfm_pkg::LEN_MID: begin
                n_ext    = wsfm_pkg::EXT_BYTES_MID;
                len_code = wsfm_pkg::LEN_CODE_16;
            end
            wsfm_pkg::LEN_LONG: begin
                n_ext    = wsfm_pkg::EXT_BYTES_LONG;
                len_code = wsfm_pkg::LEN_CODE_64;
            end
            default: begin
                n_ext    = wsfm_pkg::EXT_BYTES_SHORT;
                len_code = head_job.length[6:0] & wsfm_pkg::LEN_CODE_MAX;
            end
        endcase
        last_pos = n_ext + 4'd5;
        ext_idx  = pos_reg - 4'd2;
        ext_sel  = n_ext - 4'd1 - ext_idx;
        key_idx  = ext_idx - n_ext;
        len64    = {1'b0, head_job.length};

        if (pos_reg == 4'd0) begin
            hdr_byte = wsfm_pkg::HDR_FIN | {4'h0, head_job.opcode};
        end else if (pos_reg == 4'd1) begin
            hdr_byte = wsfm_pkg::HDR_MASK_BIT | {1'b0, len_code};
        end else if (ext_idx < n_ext) begin
            hdr_byte = len64[{ext_sel[2:0], 3'b000} +: 8];
        end else begin
            hdr_byte = head_job.key[{~key_idx[1:0], 3'b000} +: 8];
        end

        pos_next      = pos_reg;
        pop           = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;

        if (step) begin
            m_tvalid_next = 1'b1;
            case (head_job.kind)
                wsfm_pkg::JOB_HEADER: begin
                    m_tdata_next = hdr_byte;
                    m_tlast_next = (pos_reg == last_pos) && (head_job.length == 63'd0);
                    m_tuser_next = 1'b0;
                    if (pos_reg == last_pos) begin
                        pop      = 1'b1;
                        pos_next = 4'd0;
                    end else begin
                        pos_next = pos_reg + 4'd1;
                    end
                end
                wsfm_pkg::JOB_DATA: begin
                    m_tdata_next = head_job.data;
                    m_tlast_next = head_job.last;
                    m_tuser_next = 1'b0;
                    pop          = 1'b1;
                end
                default: begin
                    m_tdata_next = 8'h00;
                    m_tlast_next = 1'b0;
                    m_tuser_next = 1'b1;
                    pop          = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tlast    = m_tlast_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_error_word_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg |-> (m_tdata_reg == 8'h00) && !m_tlast_reg)
        else $error("error word carries data or last");

    a_pos_only_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 4'd0 |-> head_valid && (head_job.kind == wsfm_pkg::JOB_HEADER))
        else $error("header position set outside a header job");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 4'd13)
        else $error("header position beyond longest header");

endmodule

// File: sv/websocket_frame_masking_framer.sv
// Masked client WebSocket frame encoder, top level.
// Slave channel s_*: tuser[0] is the command (0 start frame, 1 payload byte);
// tdata carries opcode [3:0], payload length [66:4], masking key [98:67] and
// the payload byte [106:99]. Master channel m_*: tdata is the wire byte, tlast
// marks the final byte of a frame, tuser[0] flags a dropped out-of-sequence word.
// A start word yields 6, 8 or 14 output words (header, extended length, key);
// a payload word or a dropped word yields one.
// An input word is registered in the job queue, then in the output register.
// Throughput: one payload byte per cycle while m_tready is high; a start
// occupies the back end until all its header words are out, while the front
// keeps taking words into a QUEUE_DEPTH-entry job queue.
// Reset clears frame state, the queue and the output register; no frame is open.
// When m_tready is low the output word holds, the back end waits and the queue
// fills; s_tready drops only once the queue is full.
// Depends on wsfm_pkg, wsfm_front, wsfm_queue, wsfm_back.
module websocket_frame_masking_framer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wsfm_pkg::S_TDATA_W-1:0]    s_tdata,  // opcode, length, key, data byte
    input  logic [0:0]                        s_tuser,  // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wsfm_pkg::M_TDATA_W-1:0]    m_tdata,  // wire byte
    output logic                              m_tlast,
    output logic [0:0]                        m_tuser   // error flag
);

    logic           q_full;
    logic           q_push;
    wsfm_pkg::job_t q_job;
    logic           q_pop;
    logic           head_valid;
    wsfm_pkg::job_t head_job;

    wsfm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (q_job)
    );

    wsfm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    wsfm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for websocket_frame_masking_framer: queued stimulus, in-bench frame encoder
// and a word-by-word check of the masked wire stream with random gaps and stalls.
// Depends on wsfm_pkg and the framer RTL.
module tb_top;

    localparam logic [62:0] LEN_MID_MAX = 63'd65535;
    localparam int unsigned DRAIN_CYCLES = 32;

    typedef struct {
        logic        cmd;
        logic [3:0]  opcode;
        logic [62:0] length;
        logic [31:0] key;
        logic [7:0]  data;
    } frame_word_t;

    typedef struct {
        logic [7:0] wire_byte;
        logic       last;
        logic       dropped;
    } wire_word_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [wsfm_pkg::S_TDATA_W-1:0]     s_tdata  = '0;
    logic [0:0]                         s_tuser  = '0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [wsfm_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               m_tlast;
    logic [0:0]                         m_tuser;

    frame_word_t words_to_send[$];
    wire_word_t  wire_bytes_due[$];
    frame_word_t word_on_bus;
    int          mismatch_count = 0;

    // encoder state
    logic [62:0] bytes_left  = '0;
    logic [31:0] frame_key   = '0;
    logic [1:0]  key_pos     = '0;
    logic        frame_is_open = 1'b0;

    int burst_left = 1;
    int gap_left   = 0;
    int rx_mode    = 0;
    int rx_count   = 0;

    websocket_frame_masking_framer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic expect_byte(input logic [7:0] b, input logic last, input logic dropped);
        wire_word_t w;
        w.wire_byte = b;
        w.last      = last;
        w.dropped   = dropped;
        wire_bytes_due.push_back(w);
    endtask

    task automatic encode_word(input frame_word_t fw);
        logic [63:0] len64;
        len64 = {1'b0, fw.length};
        if (fw.cmd == wsfm_pkg::CMD_START) begin
            if (frame_is_open) begin
                expect_byte(8'h00, 1'b0, 1'b1);
                return;
            end
            expect_byte(wsfm_pkg::HDR_FIN | {4'h0, fw.opcode}, 1'b0, 1'b0);
            if (fw.length > LEN_MID_MAX) begin
                expect_byte(wsfm_pkg::HDR_MASK_BIT | {1'b0, wsfm_pkg::LEN_CODE_64},
                            1'b0, 1'b0);
                for (int i = 7; i >= 0; i--)
                    expect_byte(len64[8*i +: 8], 1'b0, 1'b0);
            end else if (fw.length > wsfm_pkg::LEN_SHORT_MAX) begin
                expect_byte(wsfm_pkg::HDR_MASK_BIT | {1'b0, wsfm_pkg::LEN_CODE_16},
                            1'b0, 1'b0);
                expect_byte(len64[15:8], 1'b0, 1'b0);
                expect_byte(len64[7:0], 1'b0, 1'b0);
            end else begin
                expect_byte(wsfm_pkg::HDR_MASK_BIT | {1'b0, len64[6:0]}, 1'b0, 1'b0);
            end
            for (int k = 0; k < 4; k++)
                expect_byte(fw.key[8*(3-k) +: 8], (k == 3) && (fw.length == '0), 1'b0);
            frame_key     = fw.key;
            key_pos       = 2'd0;
            bytes_left    = fw.length;
            frame_is_open = (fw.length != '0);
        end else begin
            if (!frame_is_open) begin
                expect_byte(8'h00, 1'b0, 1'b1);
                return;
            end
            bytes_left = bytes_left - 63'd1;
            expect_byte(fw.data ^ frame_key[8*(3-key_pos) +: 8], bytes_left == '0, 1'b0);
            key_pos = key_pos + 2'd1;
            if (bytes_left == '0)
                frame_is_open = 1'b0;
        end
    endtask

    function automatic frame_word_t start_word(input logic [3:0] opc, input logic [62:0] len,
                                               input logic [31:0] key);
        frame_word_t fw;
        fw.cmd    = wsfm_pkg::CMD_START;
        fw.opcode = opc;
        fw.length = len;
        fw.key    = key;
        fw.data   = 8'($urandom_range(0, 255));
        return fw;
    endfunction

    // unused fields carry junk; the block must ignore them
    function automatic frame_word_t payload_word(input logic [7:0] data);
        frame_word_t fw;
        fw.cmd    = wsfm_pkg::CMD_DATA;
        fw.opcode = 4'($urandom_range(0, 15));
        fw.length = 63'({$urandom(), $urandom()});
        fw.key    = $urandom();
        fw.data   = data;
        return fw;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                encode_word(word_on_bus);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left = gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    word_on_bus = words_to_send.pop_front();
                    s_tdata  <= {5'b0, word_on_bus.data, word_on_bus.key,
                                 word_on_bus.length, word_on_bus.opcode};
                    s_tuser  <= word_on_bus.cmd;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_count == 0) begin
                rx_mode  = $urandom_range(0, 3);
                rx_count = $urandom_range(16, 96);
            end
            rx_count = rx_count - 1;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (rx_count % 4 == 0);
                default: m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor
    always @(posedge aclk) begin
        wire_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (wire_bytes_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected word byte %02h last %0b err %0b",
                             $realtime, m_tdata, m_tlast, m_tuser[0]);
            end else begin
                w = wire_bytes_due.pop_front();
                if (m_tdata !== w.wire_byte || m_tlast !== w.last
                    || m_tuser[0] !== w.dropped) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: expected byte %02h last %0b err %0b, got %02h %0b %0b",
                                 $realtime, w.wire_byte, w.last, w.dropped,
                                 m_tdata, m_tlast, m_tuser[0]);
                end
            end
        end
    end

    initial begin
        int          pick;
        int          frames_made;
        int          gen_left;
        bit          gen_open;
        logic [62:0] flen;

        // directed
        words_to_send.push_back(payload_word(8'h3c));
        words_to_send.push_back(start_word(4'h0, 63'd0, 32'h0000_0000));
        words_to_send.push_back(start_word(4'hf, 63'd2, 32'hffff_ffff));
        words_to_send.push_back(start_word(4'h5, 63'd7, 32'h1234_5678));
        words_to_send.push_back(payload_word(8'h00));
        words_to_send.push_back(payload_word(8'hff));
        words_to_send.push_back(payload_word(8'hff));
        words_to_send.push_back(start_word(4'h8, 63'd5, 32'ha5c3_0f81));
        words_to_send.push_back(payload_word(8'hff));
        words_to_send.push_back(payload_word(8'h00));
        words_to_send.push_back(payload_word(8'h5a));
        words_to_send.push_back(payload_word(8'ha5));
        words_to_send.push_back(payload_word(8'h3c));
        words_to_send.push_back(start_word(4'h2, 63'd0, 32'h8765_4321));
        words_to_send.push_back(start_word(4'h9, 63'd1, 32'h00ff_00ff));
        words_to_send.push_back(payload_word(8'h81));

        // random frames, with some stray and out-of-sequence words
        frames_made = 0;
        gen_left    = 0;
        gen_open    = 1'b0;
        while (words_to_send.size() < 350) begin
            pick = $urandom_range(0, 99);
            if (!gen_open) begin
                if (pick < 8) begin
                    words_to_send.push_back(payload_word(8'($urandom_range(0, 255))));
                end else begin
                    if (frames_made == 0) begin
                        flen = wsfm_pkg::LEN_SHORT_MAX;
                    end else if (frames_made == 1) begin
                        flen = wsfm_pkg::LEN_SHORT_MAX + 63'd1;
                    end else begin
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            flen = wsfm_pkg::LEN_SHORT_MAX;
                        else if (pick == 1)
                            flen = 63'($urandom_range(126, 240));
                        else if (pick < 5)
                            flen = 63'($urandom_range(9, 124));
                        else
                            flen = 63'($urandom_range(0, 8));
                    end
                    frames_made++;
                    words_to_send.push_back(start_word(4'($urandom_range(0, 15)), flen,
                                                       $urandom()));
                    gen_left = int'(flen);
                    gen_open = (flen != '0);
                end
            end else if (pick < 5) begin
                words_to_send.push_back(start_word(4'($urandom_range(0, 15)),
                                                   63'($urandom_range(0, 300)), $urandom()));
            end else begin
                words_to_send.push_back(payload_word(8'($urandom_range(0, 255))));
                gen_left--;
                if (gen_left == 0)
                    gen_open = 1'b0;
            end
        end
        while (gen_open) begin
            words_to_send.push_back(payload_word(8'($urandom_range(0, 255))));
            gen_left--;
            if (gen_left == 0)
                gen_open = 1'b0;
        end

        // longest length last: this frame is never closed
        words_to_send.push_back(start_word(4'($urandom_range(0, 15)), '1, $urandom()));
        repeat (6)
            words_to_send.push_back(payload_word(8'($urandom_range(0, 255))));
        words_to_send.push_back(start_word(4'($urandom_range(0, 15)), 63'd3, $urandom()));
        words_to_send.push_back(payload_word(8'($urandom_range(0, 255))));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        do
            @(negedge aclk);
        while (words_to_send.size() != 0 || s_tvalid || wire_bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0)
            $display("[websocket_frame_masking_framer] OK");
        else
            $display("[websocket_frame_masking_framer] ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[websocket_frame_masking_framer] ERROR");
        $finish;
    end

endmodule
